// File: rtl/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16LE transcoder.
// No dependencies; every other file of the block imports this package.
package u8u16_pkg;

    // Code point as gathered from UTF-8, and one UTF-16 unit
    typedef logic [20:0] cp_t;
    typedef logic [15:0] unit_t;

    // Default number of finished code points held between decoder and emitter
    localparam int QUEUE_DEPTH = 4;

    // Surrogate arithmetic
    localparam cp_t   SUPP_BASE = 21'h10000;
    localparam unit_t HIGH_SURR = 16'hD800;
    localparam unit_t LOW_SURR  = 16'hDC00;

    // Following bytes due after each kind of lead byte
    localparam logic [1:0] NEED_NONE  = 2'd0;
    localparam logic [1:0] NEED_ONE   = 2'd1;
    localparam logic [1:0] NEED_TWO   = 2'd2;
    localparam logic [1:0] NEED_THREE = 2'd3;

    // Queue status seen by the decoder and the emitter
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// File: rtl/u8u16_front.sv
// Byte decoder: accepts UTF-8 bytes and assembles finished code points.
// Depends on u8u16_pkg; pushes into u8u16_queue.
module u8u16_front
    import u8u16_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic [7:0] byte_in,
    input  logic      end_of_string,
    input  q_status_t q_status,
    output logic      push,
    output cp_t       push_cp
);

    cp_t        partial_reg, partial_next;
    logic [1:0] pending_reg, pending_next;

    logic       accept;
    logic [1:0] lead_need;
    cp_t        lead_val;
    logic [1:0] pend_dec;
    cp_t        merged;
    logic       emit;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    // Lead byte classification
    always_comb
    begin
        if (byte_in[7:4] == 4'hF)
        begin
            lead_need = NEED_THREE;
            lead_val  = cp_t'(byte_in[2:0]);
        end
        else if (byte_in[7:5] == 3'b111)
        begin
            lead_need = NEED_TWO;
            lead_val  = cp_t'(byte_in[3:0]);
        end
        else if (byte_in[7:6] == 2'b11)
        begin
            lead_need = NEED_ONE;
            lead_val  = cp_t'(byte_in[4:0]);
        end
        else
        begin
            lead_need = NEED_NONE;
            lead_val  = cp_t'(byte_in);
        end
    end

    // Follower merge: any byte adds its low six bits
    assign merged   = {partial_reg[14:0], byte_in[5:0]};
    assign pend_dec = pending_reg - 2'd1;

    // Next decoder state and code point handed on
    always_comb
    begin
        partial_next = partial_reg;
        pending_next = pending_reg;
        if (pending_reg == NEED_NONE)
        begin
            push_cp = lead_val;
            emit    = (lead_need == NEED_NONE) || end_of_string;
            if (accept && !emit)
            begin
                partial_next = lead_val;
                pending_next = lead_need;
            end
        end
        else
        begin
            push_cp = merged;
            emit    = (pend_dec == NEED_NONE) || end_of_string;
            if (accept && !emit)
            begin
                partial_next = merged;
                pending_next = pend_dec;
            end
        end
        if (accept && emit)
        begin
            partial_next = '0;
            pending_next = NEED_NONE;
        end
    end

    assign push = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            pending_reg <= NEED_NONE;
        end
        else
        begin
            partial_reg <= partial_next;
            pending_reg <= pending_next;
        end
    end

    // A partial value never holds more than three bytes' worth of bits
    a_partial_narrow: assert property (@(posedge clk) disable iff (!rst_n)
        partial_reg[20:15] == '0)
        else $error("partial code point wider than expected");

    // The end of a string always leaves the decoder clear
    a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_string |=> pending_reg == NEED_NONE && partial_reg == '0)
        else $error("decoder state left over after end of string");

    // Nothing is pushed into a full queue
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("code point pushed into full queue");

endmodule

// File: rtl/u8u16_queue.sv
// Short queue of finished code points between decoder and unit emitter.
// Depends on u8u16_pkg.
module u8u16_queue
    import u8u16_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cp_t       push_cp,
    input  logic      pop,
    output cp_t       head_cp,
    output q_status_t q_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cp_t              store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign q_status.full  = (count_reg == FULL_CNT);
    assign q_status.empty = (count_reg == '0);
    assign head_cp        = store_reg[rd_ptr_reg];

    // Pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_cp;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_status.full))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && q_status.empty))
        else $error("queue underflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count out of range");

endmodule

// File: rtl/u8u16_back.sv
// Unit emitter: turns queued code points into one unit or a surrogate pair.
// Depends on u8u16_pkg; pops from u8u16_queue and drives the output register.
module u8u16_back
    import u8u16_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cp_t       head_cp,
    input  q_status_t q_status,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output unit_t     code_unit,
    output logic      last_unit
);

    logic  out_valid_reg;
    logic  low_pending_reg;
    unit_t code_unit_reg;
    logic  last_unit_reg;
    unit_t low_unit_reg;

    logic  take;
    logic  is_pair;
    cp_t   offset;
    unit_t high_unit;
    unit_t low_unit;

    // Output register may load when empty or being drained
    assign take = !out_valid_reg || out_ready;
    assign pop  = take && !low_pending_reg && !q_status.empty;

    // Surrogate split
    assign is_pair   = (head_cp[20:16] != '0);
    assign offset    = head_cp - SUPP_BASE;
    assign high_unit = HIGH_SURR + unit_t'(offset[20:10]);
    assign low_unit  = LOW_SURR | unit_t'(offset[9:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            low_pending_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg   <= low_pending_reg || !q_status.empty;
            low_pending_reg <= !low_pending_reg && pop && is_pair;
        end
    end

    // Unit payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (low_pending_reg)
            begin
                code_unit_reg <= low_unit_reg;
                last_unit_reg <= 1'b1;
            end
            else if (pop)
            begin
                code_unit_reg <= is_pair ? high_unit : head_cp[15:0];
                last_unit_reg <= !is_pair;
                low_unit_reg  <= low_unit;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign code_unit = code_unit_reg;
    assign last_unit = last_unit_reg;

    // A waiting low surrogate always sits behind a shown high surrogate
    a_low_behind_high: assert property (@(posedge clk) disable iff (!rst_n)
        low_pending_reg |-> out_valid_reg && !last_unit_reg)
        else $error("low surrogate pending without high unit shown");

    // The low surrogate follows as the closing unit
    a_low_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        low_pending_reg && take |=> out_valid_reg && last_unit_reg)
        else $error("low surrogate not emitted as last unit");

    // No new code point is taken while a pair is half sent
    a_no_pop_mid_pair: assert property (@(posedge clk) disable iff (!rst_n)
        low_pending_reg |-> !pop)
        else $error("queue popped in the middle of a surrogate pair");

endmodule

// File: rtl/utf8_to_utf16le_transcoder_unit.sv
// Top level of the UTF-8 to UTF-16LE transcoder.
// Depends on u8u16_pkg, u8u16_front, u8u16_queue and u8u16_back.
//
// Takes one UTF-8 byte per cycle, with end_of_string on the final byte of a
// string, and gives UTF-16 code units with last_unit on the final unit that
// a byte causes. Decoding is lenient: stray continuation bytes pass through
// as their own value, following bytes are merged whatever their top bits, a
// sequence cut short by end_of_string gives its partial value, and values
// above 0x10FFFF still form a surrogate pair.
// The decoder accepts a byte every cycle while the code point queue has room;
// a finished code point is written into the queue and then loaded into the
// output register. A code point of 0x10000 or more gives a high and a low
// surrogate unit, so the sustained rate is one byte per cycle and the output
// side sets the pace only through the QUEUE_DEPTH_P-entry queue filling up.
module utf8_to_utf16le_transcoder_unit
    import u8u16_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_in,
    input  logic        end_of_string,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] code_unit,
    output logic        last_unit
);

    q_status_t q_status;
    logic      push;
    cp_t       push_cp;
    logic      pop;
    cp_t       head_cp;

    // Byte decoder
    u8u16_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .byte_in       (byte_in),
        .end_of_string (end_of_string),
        .q_status      (q_status),
        .push          (push),
        .push_cp       (push_cp)
    );

    // Code point queue
    u8u16_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cp  (push_cp),
        .pop      (pop),
        .head_cp  (head_cp),
        .q_status (q_status)
    );

    // Unit emitter
    u8u16_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_cp   (head_cp),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .code_unit (code_unit),
        .last_unit (last_unit)
    );

endmodule

// File: verif/u8u16_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the UTF-8 to UTF-16LE transcoder testbench.
// Depends on u8u16_pkg for the code point and unit types and the constants.
package u8u16_tb_pkg;

    import u8u16_pkg::*;

    // One expected UTF-16 unit with its end-of-byte flag
    typedef struct packed {
        unit_t code;
        logic  last;
    } utf16_item_t;

    class utf16_scoreboard;

        // Decoder state as the block should hold it
        cp_t         gathered;
        logic [1:0]  followers_due;
        utf16_item_t expected_units[$];
        int unsigned mismatches;

        function new();
            gathered      = '0;
            followers_due = NEED_NONE;
            mismatches    = 0;
        endfunction

        // Append one expected unit at the tail
        function void add_unit(unit_t u, logic l);
            utf16_item_t item;
            item.code = u;
            item.last = l;
            expected_units.insert(expected_units.size(), item);
        endfunction

        // One unit below 0x10000, else a high/low surrogate pair
        function void push_code_point(cp_t cp);
            cp_t offset;
            if (cp >= SUPP_BASE)
            begin
                offset = cp - SUPP_BASE;
                add_unit(HIGH_SURR + {5'd0, offset[20:10]}, 1'b0);
                add_unit(LOW_SURR + {6'd0, offset[9:0]}, 1'b1);
            end
            else
            begin
                add_unit(cp[15:0], 1'b1);
            end
        endfunction

        // Note an accepted input item and queue the units it completes
        function void take_byte(logic [7:0] b, logic eos);
            cp_t        cp;
            logic [1:0] due;
            if (followers_due == NEED_NONE)
            begin
                due = NEED_NONE;
                cp  = {13'd0, b};
                if (b >= 8'hF0)
                begin
                    cp  = {18'd0, b[2:0]};
                    due = NEED_THREE;
                end
                else if (b >= 8'hE0)
                begin
                    cp  = {17'd0, b[3:0]};
                    due = NEED_TWO;
                end
                else if (b >= 8'hC0)
                begin
                    cp  = {16'd0, b[4:0]};
                    due = NEED_ONE;
                end
                // lead byte on the final byte is emitted at once
                if (due != NEED_NONE && !eos)
                begin
                    gathered      = cp;
                    followers_due = due;
                    return;
                end
            end
            else
            begin
                // any byte merges as a follower, top bits ignored
                cp            = {gathered[14:0], b[5:0]};
                followers_due = followers_due - 2'd1;
                if (followers_due != NEED_NONE && !eos)
                begin
                    gathered = cp;
                    return;
                end
            end
            gathered      = '0;
            followers_due = NEED_NONE;
            push_code_point(cp);
        endfunction

        // Compare an accepted result item with the oldest expectation
        function void check_unit(unit_t code, logic last);
            utf16_item_t want;
            if (expected_units.size() == 0)
            begin
                $error("unexpected unit: code_unit %h last_unit %b", code, last);
                mismatches++;
                return;
            end
            want = expected_units.pop_front();
            if (code !== want.code)
            begin
                $error("code_unit: expected %h, actual %h", want.code, code);
                mismatches++;
            end
            if (last !== want.last)
            begin
                $error("last_unit: expected %b, actual %b", want.last, last);
                mismatches++;
            end
        endfunction

    endclass

endpackage

// File: verif/tb_utf8_to_utf16le_transcoder_unit.sv
`timescale 1ns / 1ps
// Testbench top for utf8_to_utf16le_transcoder_unit: directed and random byte
// streams with random stalls on both sides. Depends on u8u16_pkg, u8u16_tb_pkg.
module tb_utf8_to_utf16le_transcoder_unit;

    import u8u16_pkg::*;
    import u8u16_tb_pkg::*;

    localparam int unsigned STALL_LIMIT  = 4000;
    localparam int unsigned BYTE_TARGET  = 1050;
    localparam int unsigned QUIET_AFTER  = 900;
    localparam int unsigned HOLD_AT      = 300;
    localparam int unsigned HOLD_CYCLES  = 150;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_ready;
    logic [7:0]  byte_in       = 8'h00;
    logic        end_of_string = 1'b0;
    logic        out_valid;
    logic        out_ready     = 1'b0;
    logic [15:0] code_unit;
    logic        last_unit;

    utf16_scoreboard sb = new();
    int unsigned bytes_sent     = 0;
    int unsigned bytes_accepted = 0;
    int unsigned idle_cycles    = 0;
    bit          quiet          = 1'b0;
    bit          hold_done      = 1'b0;

    // {end_of_string, byte}: ASCII extremes, stray continuations, 2/3/4-byte
    // forms, value above 0x10FFFF, lead on final byte, cut-short sequence,
    // lead merged as follower
    logic [8:0] directed_items [0:23] = '{
        9'h100, 9'h07F, 9'h080, 9'h1BF,
        9'h0C2, 9'h0A9,
        9'h0E2, 9'h082, 9'h0AC,
        9'h0F0, 9'h09F, 9'h098, 9'h080,
        9'h0FF, 9'h0FF, 9'h0FF, 9'h1FF,
        9'h1E0,
        9'h0F4, 9'h180,
        9'h0C3, 9'h0C3,
        9'h0DF, 9'h141
    };

    utf8_to_utf16le_transcoder_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .byte_in       (byte_in),
        .end_of_string (end_of_string),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .code_unit     (code_unit),
        .last_unit     (last_unit)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Accepted items on both sides go to the scoreboard
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            sb.take_byte(byte_in, end_of_string);
            bytes_accepted <= bytes_accepted + 1;
        end
        if (rst_n && out_valid && out_ready)
            sb.check_unit(code_unit, last_unit);
    end

    // Watchdog: cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Receiver: random stall bursts, one long hold-off to fill the block
    initial
    begin
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!hold_done && bytes_accepted >= HOLD_AT)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // Offer one byte, possibly after a gap, and wait for its acceptance
    task automatic send_byte(logic [7:0] b, logic eos);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        byte_in       <= b;
        end_of_string <= eos;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
        if (bytes_sent >= QUIET_AFTER)
            quiet = 1'b1;
    endtask

    // Well-formed sequence of len bytes with random content, first keep sent
    task automatic send_sequence(int unsigned len, int unsigned keep, logic eos_last);
        logic [7:0] b;
        for (int i = 0; i < keep; i++)
        begin
            if (i == 0)
            begin
                case (len)
                    1:       b = 8'($urandom_range(0, 127));
                    2:       b = {3'b110, 5'($urandom)};
                    3:       b = {4'b1110, 4'($urandom)};
                    default: b = {4'b1111, 4'($urandom)};
                endcase
            end
            else
                b = {2'b10, 6'($urandom)};
            send_byte(b, (i == keep - 1) ? eos_last : 1'b0);
        end
    endtask

    // Main stimulus
    initial
    begin
        int unsigned kind;
        int unsigned len;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_items[i])
            send_byte(directed_items[i][7:0], directed_items[i][8]);

        while (bytes_sent < BYTE_TARGET)
        begin
            kind = $urandom_range(0, 9);
            len  = $urandom_range(1, 4);
            if (kind <= 6)
                send_sequence(len, len, $urandom_range(0, 3) == 0);
            else if (kind == 7)
            begin
                // sequence cut short by the end of the string
                len = $urandom_range(2, 4);
                send_sequence(len, $urandom_range(1, len - 1), 1'b1);
            end
            else
            begin
                // noise: arbitrary bytes, arbitrary string ends
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom), $urandom_range(0, 7) == 0);
            end
        end
        // close any open sequence
        send_byte(8'h41, 1'b1);
        in_valid <= 1'b0;

        while (sb.expected_units.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
